FILE: src/text_glyph_framebuffer_refresh_unit_defines.svh
// ----------------------------------------------------------------------------
// Text glyph framebuffer refresh unit - assertion macros
// Concurrent assertion forms used by the tgfb_ctrl RTL module.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_FRAMEBUFFER_REFRESH_UNIT_DEFINES_SVH
`define TEXT_GLYPH_FRAMEBUFFER_REFRESH_UNIT_DEFINES_SVH

// same-cycle implication, reset-gated
`define TGFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-gated
`define TGFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tgfb_pkg.sv
// ----------------------------------------------------------------------------
// tgfb_pkg
// Constants, codes and shared types of the text glyph framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgfb_pkg;

  localparam int COLUMNS       = 128;
  localparam int GLYPH_COLUMNS = 12;
  localparam int GLYPH_BYTES   = 25;
  localparam int GLYPH_COUNT   = 96;
  localparam int FIRST_SYMBOL  = 32;

  localparam int FONT_SIZE  = GLYPH_BYTES * GLYPH_COUNT;
  localparam int FONT_AW    = $clog2(FONT_SIZE);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int FRAME_AW   = COL_W + 1;           // line select + column
  localparam int FRAME_WORDS = 2 * COLUMNS;        // one 16-bit word per column per line
  localparam int PAGE_SPAN  = 3 + COLUMNS;
  localparam int K_W        = $clog2(PAGE_SPAN);
  localparam int STEP_W     = $clog2(GLYPH_BYTES + 1);

  localparam logic [7:0] DISP_COL_LO = 8'h00;
  localparam logic [7:0] DISP_COL_HI = 8'h10;
  localparam logic [7:0] DISP_PAGE   = 8'hB0;

  localparam logic [1:0] LINE_TOP    = 2'd1;
  localparam logic [1:0] LINE_BOTTOM = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_BEGIN   = 3'd1,
    CMD_PLACE   = 3'd2,
    CMD_END     = 3'd3,
    CMD_REFRESH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GLYPH,
    S_REFR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic                font_we;
    logic [FONT_AW-1:0]  font_addr;
    logic [7:0]          font_wdata;
    logic                frame_we;
    logic [FRAME_AW-1:0] frame_addr;
    logic [15:0]         frame_wdata;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: src/tgfb_ram.sv
// ----------------------------------------------------------------------------
// tgfb_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tgfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/tgfb_ctrl.sv
// ----------------------------------------------------------------------------
// tgfb_ctrl
// Command sequencer: glyph blit loop, cursors, refresh position, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_glyph_framebuffer_refresh_unit_defines.svh"

module tgfb_ctrl
  import tgfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        invert,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [1:0]  in_line,
  input  wire logic [7:0]  in_symbol,
  input  wire logic [11:0] in_font_addr,
  input  wire logic [7:0]  in_font_data,
  output mem_req_t         mem_req,
  input  wire logic [7:0]  font_rdata,
  input  wire logic [15:0] frame_rdata,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res
);

  state_t state_r, state_nxt;

  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [FONT_AW-1:0]     base_r, base_nxt;
  logic                   bottom_r, bottom_nxt;
  logic [7:0]             width_r, width_nxt;
  logic [7:0]             upper_r, upper_nxt;
  logic                   oob_r, oob_nxt;
  logic [7:0]             cur_top_r, cur_top_nxt;
  logic [7:0]             cur_bot_r, cur_bot_nxt;
  logic                   top_full_r, top_full_nxt;
  logic                   bot_full_r, bot_full_nxt;
  logic [1:0]             page_r, page_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic [FRAME_WORDS-1:0] fvalid_r, fvalid_nxt;
  logic                   rvld_r, rvld_nxt;
  logic                   sel_hi_r, sel_hi_nxt;
  res_t                   res_r, res_nxt;

  cmd_t cmd;
  logic accept;
  assign cmd    = cmd_t'(in_cmd);
  assign accept = (state_r == S_IDLE) && in_valid;

  // place-glyph checks at accept
  logic                 in_bottom;
  logic                 sym_bad;
  logic                 sel_full;
  logic [7:0]           sym_off;
  logic [FONT_AW-1:0]   sym_base;
  assign in_bottom = (in_line == LINE_BOTTOM);
  assign sym_bad   = ({1'b0, in_symbol} < 9'(FIRST_SYMBOL)) ||
                     ({1'b0, in_symbol} >= 9'(FIRST_SYMBOL + GLYPH_COUNT));
  assign sel_full  = in_bottom ? bot_full_r : top_full_r;
  assign sym_off   = in_symbol - 8'(FIRST_SYMBOL);
  assign sym_base  = FONT_AW'(sym_off) * FONT_AW'(GLYPH_BYTES);

  // blit datapath: font read issue and frame write
  logic [FONT_AW:0]     faddr_full;
  logic [STEP_W-1:0]    didx;
  logic                 have_data;
  logic [7:0]           fbyte;
  logic [STEP_W-2:0]    col_i;
  logic [7:0]           cur;
  logic [8:0]           col;
  logic                 wr_en;
  logic [FRAME_AW-1:0]  waddr;
  logic                 blit_done;
  logic [8:0]           next_cur;

  assign faddr_full = {1'b0, base_r} + (FONT_AW + 1)'(step_r);
  assign didx       = step_r - STEP_W'(1);
  assign have_data  = (state_r == S_GLYPH) && (step_r != '0);
  assign fbyte      = oob_r ? 8'h00 : font_rdata;
  assign col_i      = didx[STEP_W-1:1] - (STEP_W - 1)'(1);
  assign cur        = bottom_r ? cur_bot_r : cur_top_r;
  assign col        = {1'b0, cur} + 9'(col_i);
  assign wr_en      = have_data && !didx[0] && (didx != '0) &&
                      (didx <= STEP_W'(2 * GLYPH_COLUMNS)) && (col < 9'(COLUMNS));
  assign waddr      = {bottom_r, col[COL_W-1:0]};
  assign blit_done  = (state_r == S_GLYPH) && (step_r == STEP_W'(GLYPH_BYTES));
  assign next_cur   = {1'b0, cur} + {1'b0, width_r};

  // refresh addressing
  logic [K_W-1:0]      k_col;
  logic [FRAME_AW-1:0] raddr;
  logic                k_last;
  assign k_col  = k_r - K_W'(3);
  assign raddr  = {page_r[1], k_col[COL_W-1:0]};
  assign k_last = (k_r == K_W'(PAGE_SPAN - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_FIN;
          if (cmd == CMD_PLACE && !sym_bad && !sel_full) begin
            state_nxt = S_GLYPH;
          end else if (cmd == CMD_REFRESH && k_r >= K_W'(3)) begin
            state_nxt = S_REFR;
          end
        end
      end
      S_GLYPH: begin
        if (blit_done) begin
          state_nxt = S_FIN;
        end
      end
      S_REFR: state_nxt = S_FIN;
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs: handshakes and memory port control
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && cmd == CMD_LOAD &&
            {1'b0, in_font_addr} < 13'(FONT_SIZE)) begin
          mem_req.font_we    = 1'b1;
          mem_req.font_addr  = FONT_AW'(in_font_addr);
          mem_req.font_wdata = in_font_data;
        end
        mem_req.frame_addr = raddr;
      end
      S_GLYPH: begin
        mem_req.font_addr   = faddr_full[FONT_AW-1:0];
        mem_req.frame_we    = wr_en;
        mem_req.frame_addr  = waddr;
        mem_req.frame_wdata = {fbyte, upper_r};
      end
      S_REFR: ;
      S_FIN: res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    step_nxt     = step_r;
    base_nxt     = base_r;
    bottom_nxt   = bottom_r;
    width_nxt    = width_r;
    upper_nxt    = upper_r;
    oob_nxt      = oob_r;
    cur_top_nxt  = cur_top_r;
    cur_bot_nxt  = cur_bot_r;
    top_full_nxt = top_full_r;
    bot_full_nxt = bot_full_r;
    page_nxt     = page_r;
    k_nxt        = k_r;
    fvalid_nxt   = fvalid_r;
    rvld_nxt     = rvld_r;
    sel_hi_nxt   = sel_hi_r;
    res_nxt      = res_r;

    if (accept) begin
      res_nxt = '0;
      unique case (cmd)
        CMD_LOAD: ;
        CMD_BEGIN: begin
          if (in_line == LINE_TOP) begin
            fvalid_nxt[COLUMNS-1:0] = '0;
            cur_top_nxt  = '0;
            top_full_nxt = 1'b0;
          end else if (in_line == LINE_BOTTOM) begin
            fvalid_nxt[FRAME_WORDS-1:COLUMNS] = '0;
            cur_bot_nxt  = '0;
            bot_full_nxt = 1'b0;
          end
        end
        CMD_PLACE: begin
          if (sym_bad) begin
            res_nxt.status = STAT_BAD;
          end else if (sel_full) begin
            res_nxt.status = STAT_FULL;
          end else begin
            step_nxt   = '0;
            base_nxt   = sym_base;
            bottom_nxt = in_bottom;
          end
        end
        CMD_END: begin
          cur_top_nxt  = '0;
          cur_bot_nxt  = '0;
          top_full_nxt = 1'b0;
          bot_full_nxt = 1'b0;
        end
        CMD_REFRESH: begin
          res_nxt.byte_valid = 1'b1;
          case (k_r)
            K_W'(0): res_nxt.out_byte = DISP_COL_LO;
            K_W'(1): res_nxt.out_byte = DISP_COL_HI;
            K_W'(2): res_nxt.out_byte = DISP_PAGE | {6'd0, page_r};
            default: begin
              res_nxt.is_data   = 1'b1;
              res_nxt.frame_end = (page_r == 2'd3) && k_last;
            end
          endcase
          sel_hi_nxt = page_r[0];
          rvld_nxt   = fvalid_r[raddr];
          if (k_last) begin
            k_nxt    = '0;
            page_nxt = page_r + 2'd1;
          end else begin
            k_nxt = k_r + K_W'(1);
          end
        end
        default: ;
      endcase
    end

    if (state_r == S_GLYPH) begin
      if (!blit_done) begin
        step_nxt = step_r + STEP_W'(1);
      end
      oob_nxt = (faddr_full >= (FONT_AW + 1)'(FONT_SIZE));
      if (have_data && didx == '0) begin
        width_nxt = fbyte;
      end
      if (have_data && didx[0]) begin
        upper_nxt = fbyte;
      end
      if (wr_en) begin
        fvalid_nxt[waddr] = 1'b1;
      end
      if (blit_done) begin
        // saturate cursor, line is full once it passes the last column
        if (bottom_r) begin
          cur_bot_nxt = next_cur[8] ? 8'hFF : next_cur[7:0];
        end else begin
          cur_top_nxt = next_cur[8] ? 8'hFF : next_cur[7:0];
        end
        if (next_cur > 9'(COLUMNS - 1)) begin
          res_nxt.status = STAT_FULL;
          if (bottom_r) begin
            bot_full_nxt = 1'b1;
          end else begin
            top_full_nxt = 1'b1;
          end
        end
      end
    end

    if (state_r == S_REFR) begin
      res_nxt.out_byte = (rvld_r ? (sel_hi_r ? frame_rdata[15:8] : frame_rdata[7:0])
                                 : 8'h00) ^ {8{invert}};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_top_r  <= '0;
      cur_bot_r  <= '0;
      top_full_r <= 1'b0;
      bot_full_r <= 1'b0;
      page_r     <= '0;
      k_r        <= '0;
      fvalid_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      cur_top_r  <= cur_top_nxt;
      cur_bot_r  <= cur_bot_nxt;
      top_full_r <= top_full_nxt;
      bot_full_r <= bot_full_nxt;
      page_r     <= page_nxt;
      k_r        <= k_nxt;
      fvalid_r   <= fvalid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    base_r   <= base_nxt;
    bottom_r <= bottom_nxt;
    width_r  <= width_nxt;
    upper_r  <= upper_nxt;
    oob_r    <= oob_nxt;
    rvld_r   <= rvld_nxt;
    sel_hi_r <= sel_hi_nxt;
    res_r    <= res_nxt;
  end

  assign res = res_r;

  `TGFB_ASSERT_IMPL(a_frame_we_in_blit, clk, rst_n, mem_req.frame_we, state_r == S_GLYPH, "frame write outside blit")
  `TGFB_ASSERT_IMPL(a_step_bound, clk, rst_n, state_r == S_GLYPH, step_r <= STEP_W'(GLYPH_BYTES), "blit step overrun")
  `TGFB_ASSERT_NEXT(a_refr_to_fin, clk, rst_n, state_r == S_REFR, state_r == S_FIN, "refresh read not completed")
  `TGFB_ASSERT_IMPL(a_k_range, clk, rst_n, 1'b1, k_r < K_W'(PAGE_SPAN), "refresh position out of page")

endmodule

`default_nettype wire

FILE: src/text_glyph_framebuffer_refresh_unit.sv
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_refresh_unit
// Text controller and frame buffer for a 128x32 page-organized mono display.
// ----------------------------------------------------------------------------
// Each input word is one command; each command returns exactly one output
// word. Path per command from accept to the result: font load, begin line,
// end text and unused codes go straight to the result state; a refresh
// tick does the same for an address command byte and passes through the
// refresh state for a data byte (one registered frame RAM read); a rejected
// glyph (bad symbol or full line) goes straight to the result state, and a
// placed glyph first runs the blit loop, which fetches its 25 font bytes
// one per cycle through the single font RAM port. The frame buffer is a
// 256 x 16 RAM (one word per column per text line, upper page in the low
// byte) with a valid bit per word, so reset and begin-line clear only the
// valid bits and no clearing pass is needed. Font bytes that were never loaded
// read back as whatever the RAM holds. The output word sits in a register,
// so the next command is taken while a result waits to be drained.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_framebuffer_refresh_unit
  import tgfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: invert
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // line[1:0], symbol[9:2], font_addr[21:10],
                                       // font_data[29:22], zero pad [31:30]
  input  wire logic [2:0]  in_tuser,   // cmd[2:0]
  // display byte stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // out_byte[7:0], status[9:8], zero pad [15:10]
  output logic [1:0]       out_tuser,  // byte_valid[0], is_data[1]
  output logic             out_tlast   // frame_end
);

  logic invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      invert_r <= cfg_wdata;
    end
  end

  mem_req_t    mem_req;
  logic [7:0]  font_rdata;
  logic [15:0] frame_rdata;
  logic        res_valid;
  logic        res_ready;
  res_t        res;

  // font glyphs: width byte then column pairs, 25 bytes per glyph
  tgfb_ram #(
    .WIDTH (8),
    .DEPTH (FONT_SIZE)
  ) u_font_ram (
    .clk   (clk),
    .we    (mem_req.font_we),
    .addr  (mem_req.font_addr),
    .wdata (mem_req.font_wdata),
    .rdata (font_rdata)
  );

  // frame: {lower page byte, upper page byte} per column of each text line
  tgfb_ram #(
    .WIDTH (16),
    .DEPTH (FRAME_WORDS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_req.frame_we),
    .addr  (mem_req.frame_addr),
    .wdata (mem_req.frame_wdata),
    .rdata (frame_rdata)
  );

  tgfb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .invert       (invert_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_cmd       (in_tuser),
    .in_line      (in_tdata[1:0]),
    .in_symbol    (in_tdata[9:2]),
    .in_font_addr (in_tdata[21:10]),
    .in_font_data (in_tdata[29:22]),
    .mem_req      (mem_req),
    .font_rdata   (font_rdata),
    .frame_rdata  (frame_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register stage
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.out_byte};
  assign out_tuser  = {out_res_r.is_data, out_res_r.byte_valid};
  assign out_tlast  = out_res_r.frame_end;

endmodule

`default_nettype wire

FILE: tb/sv/text_glyph_framebuffer_refresh_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_refresh_unit_tb
// Self-checking bench for the text glyph framebuffer. It loads font glyphs,
// writes text lines, ticks the page refresh stream and flips the invert
// register. A local copy of the font, frame, cursors and refresh position
// predicts each display word, and every output word is checked field by field.
// ----------------------------------------------------------------------------

module text_glyph_framebuffer_refresh_unit_tb;
  import tgfb_pkg::*;

  localparam int          REFRESH_LEN  = 4 * PAGE_SPAN;  // words in one full refresh
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_WORDS = 1100;
  localparam int          CALM_AFTER   = 950;    // no idling past this many random words
  localparam int          HOLD_AFTER   = 400;    // random words before the long sink hold
  localparam int          LONG_HOLD    = 400;    // cycles the sink refuses words
  localparam int          SETTLE       = 40;     // above the slowest command (placed glyph)
  localparam logic [2:0]  CMD_TOP_CODE = 3'd7;   // highest command code, unused
  localparam logic [1:0]  LINE_ALT_LO  = 2'd0;   // also selects the top line
  localparam logic [1:0]  LINE_ALT_HI  = 2'd3;   // also selects the top line
  localparam logic [11:0] ADDR_MAX     = 12'hFFF;
  localparam logic [7:0]  BYTE_MAX     = 8'hFF;

  // glyphs with fixed advance widths for the directed part
  localparam logic [7:0] SYM_NARROW = 8'(FIRST_SYMBOL);                    // width 10
  localparam logic [7:0] SYM_SPAN   = 8'(FIRST_SYMBOL + 1);                // width 120
  localparam logic [7:0] SYM_HALF   = 8'd65;                               // width 128
  localparam logic [7:0] SYM_LAST   = 8'(FIRST_SYMBOL + GLYPH_COUNT - 1);  // width 255
  localparam logic [7:0] SYM_BELOW  = 8'(FIRST_SYMBOL - 1);
  localparam logic [7:0] SYM_ABOVE  = 8'(FIRST_SYMBOL + GLYPH_COUNT);

  // --------------------------------------------------------------------------
  // Frame tracker: mirrors font store, frame pages, cursors, full flags and
  // refresh position, and keeps the display words still owed by the block.
  // --------------------------------------------------------------------------
  class glyph_frame_tracker;
    logic [7:0] font [FONT_SIZE];
    bit         font_set [FONT_SIZE];
    logic [7:0] frame [4 * COLUMNS];
    logic [7:0] cursor [2];
    bit         line_full [2];
    int         refresh_pos;
    logic       invert;
    res_t       owed_words [$];
    int         errors, checked, placed, refused_full, refused_bad, frames;

    function new();
      foreach (font[i]) begin
        font[i] = '0;
        font_set[i] = 1'b0;
      end
      foreach (frame[i]) frame[i] = '0;
      cursor[0] = '0;
      cursor[1] = '0;
      line_full[0] = 1'b0;
      line_full[1] = 1'b0;
      refresh_pos = 0;
      invert = 1'b0;
    endfunction

    function logic [7:0] font_byte(int addr);
      return (addr < FONT_SIZE) ? font[addr] : 8'h00;
    endfunction

    // all bytes of a glyph written, so placing it reads no stale RAM
    function bit glyph_ready(int sym);
      int b;
      for (b = 0; b < GLYPH_BYTES; b++)
        if (!font_set[GLYPH_BYTES * (sym - FIRST_SYMBOL) + b]) return 1'b0;
      return 1'b1;
    endfunction

    function logic [7:0] pick_loaded();
      int ready_syms [$];
      int s;
      for (s = FIRST_SYMBOL; s < FIRST_SYMBOL + GLYPH_COUNT; s++)
        if (glyph_ready(s)) ready_syms.push_back(s);
      return 8'(ready_syms[$urandom_range(0, ready_syms.size() - 1)]);
    endfunction

    function logic [1:0] place_glyph(bit bottom, logic [7:0] sym);
      int base, col, i, upper;
      int unsigned nxt;
      if (sym < FIRST_SYMBOL || sym >= FIRST_SYMBOL + GLYPH_COUNT) begin
        refused_bad++;
        return STAT_BAD;
      end
      if (line_full[bottom]) begin
        refused_full++;
        return STAT_FULL;
      end
      base  = GLYPH_BYTES * (sym - FIRST_SYMBOL);
      upper = bottom ? 2 : 0;
      for (i = 0; i < GLYPH_COLUMNS; i++) begin
        col = cursor[bottom] + i;
        if (col < COLUMNS) begin  // columns past the right edge are clipped
          frame[upper * COLUMNS + col]       = font_byte(base + 2 * i + 1);
          frame[(upper + 1) * COLUMNS + col] = font_byte(base + 2 * i + 2);
        end
      end
      nxt = cursor[bottom] + font_byte(base);
      cursor[bottom] = (nxt > 255) ? 8'hFF : nxt[7:0];
      placed++;
      if (nxt > COLUMNS - 1) begin
        line_full[bottom] = 1'b1;
        return STAT_FULL;
      end
      return STAT_OK;
    endfunction

    // one accepted command word -> one owed display word
    function void note_command(logic [2:0] code, logic [1:0] line, logic [7:0] sym,
                               logic [11:0] addr, logic [7:0] data);
      res_t e;
      int   pos, page, k;
      bit   bottom;
      e = '0;
      bottom = (line == LINE_BOTTOM);
      case (code)
        CMD_LOAD: begin
          if (addr < FONT_SIZE) begin
            font[addr] = data;
            font_set[addr] = 1'b1;
          end
        end
        CMD_BEGIN: begin
          if (line == LINE_TOP || line == LINE_BOTTOM) begin
            for (k = 0; k < 2 * COLUMNS; k++) frame[2 * int'(bottom) * COLUMNS + k] = '0;
            cursor[bottom] = '0;
            line_full[bottom] = 1'b0;
          end
        end
        CMD_PLACE: e.status = place_glyph(bottom, sym);
        CMD_END: begin
          cursor[0] = '0;
          cursor[1] = '0;
          line_full[0] = 1'b0;
          line_full[1] = 1'b0;
        end
        CMD_REFRESH: begin
          pos  = (refresh_pos < REFRESH_LEN) ? refresh_pos : 0;
          page = pos / PAGE_SPAN;
          k    = pos % PAGE_SPAN;
          e.byte_valid = 1'b1;
          if (k == 0) e.out_byte = DISP_COL_LO;
          else if (k == 1) e.out_byte = DISP_COL_HI;
          else if (k == 2) e.out_byte = DISP_PAGE | 8'(page);
          else begin
            e.out_byte = invert ? ~frame[page * COLUMNS + k - 3] : frame[page * COLUMNS + k - 3];
            e.is_data  = 1'b1;
          end
          if (pos == REFRESH_LEN - 1) begin
            e.frame_end = 1'b1;
            refresh_pos = 0;
            frames++;
          end else begin
            refresh_pos = pos + 1;
          end
        end
        default: ;  // unused codes: all fields zero
      endcase
      owed_words.push_back(e);
    endfunction

    function void check_display_word(res_t got);
      res_t e;
      if (owed_words.size() == 0) begin
        $error("display word %h with nothing owed", got);
        errors++;
        return;
      end
      e = owed_words.pop_front();
      checked++;
      if (got.byte_valid !== e.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", e.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.out_byte !== e.out_byte) begin
        $error("out_byte: expected %02h, got %02h", e.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_data !== e.is_data) begin
        $error("is_data: expected %0d, got %0d", e.is_data, got.is_data);
        errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $error("frame_end: expected %0d, got %0d", e.frame_end, got.frame_end);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals, clock, DUT
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  glyph_frame_tracker tracker = new();

  bit source_gaps  = 1'b1;   // random idle bursts on the command side
  bit sink_stalls  = 1'b1;   // random stall bursts on the display side
  bit hold_display = 1'b0;   // request for one long sink hold
  int words_sent   = 0;
  int invert_writes = 0;
  int cycle_count  = 0;

  always #5 clk = ~clk;

  text_glyph_framebuffer_refresh_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Output checker: samples pre-edge values, so no ordering race with the DUT.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_display_word('{byte_valid: out_tuser[0], out_byte: out_tdata[7:0],
                                   is_data: out_tuser[1], frame_end: out_tlast,
                                   status: out_tdata[9:8]});
  end

  // Display sink: ready most of the time, stall bursts, and one long hold that
  // lets the block fill up and push back on the command side.
  initial begin : display_sink
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_display) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_display = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_glyph_framebuffer_refresh_unit_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One command word; valid stays high after acceptance unless a gap follows,
  // so back-to-back words never lower and raise valid in one step.
  task automatic send_word(input logic [2:0] code, input logic [1:0] line,
                           input logic [7:0] sym, input logic [11:0] addr,
                           input logic [7:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {2'b00, data, addr, sym, line};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_command(code, line, sym, addr, data);
    if (code <= CMD_REFRESH) words_sent++;
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // font fields carry noise for every command but a load
  task automatic send_cmd(input logic [2:0] code, input logic [1:0] line,
                          input logic [7:0] sym);
    send_word(code, line, sym, 12'($urandom_range(0, ADDR_MAX)),
              8'($urandom_range(0, BYTE_MAX)));
  endtask

  task automatic load_glyph(input int sym, input logic [7:0] width);
    int base, b;
    base = GLYPH_BYTES * (sym - FIRST_SYMBOL);
    send_word(CMD_LOAD, 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)),
              12'(base), width);
    for (b = 1; b < GLYPH_BYTES; b++)
      send_word(CMD_LOAD, 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)),
                12'(base + b), 8'($urandom_range(0, BYTE_MAX)));
  endtask

  // sender stops and waits until every owed word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_invert(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.invert = value;
    invert_writes++;
    @(posedge clk);
  endtask

  // mostly narrow glyphs; a few zero, wide and saturating advances
  function automatic logic [7:0] pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'($urandom_range(100, 200));
    return 8'($urandom_range(4, 14));
  endfunction

  // begin a line (usually), fill it with glyphs, sometimes end the text
  task automatic text_phase();
    bit         bottom;
    logic [1:0] ln;
    logic [7:0] sym;
    bottom = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0)
      send_cmd(CMD_BEGIN, bottom ? LINE_BOTTOM : LINE_TOP, 8'($urandom_range(0, BYTE_MAX)));
    repeat ($urandom_range(3, 20)) begin
      ln = 2'($urandom_range(0, 3));
      if (bottom) ln = LINE_BOTTOM;
      else if (ln == LINE_BOTTOM) ln = LINE_TOP;
      if ($urandom_range(0, 9) == 0)
        sym = 8'($urandom_range(0, 1) ? $urandom_range(0, SYM_BELOW)
                                      : $urandom_range(SYM_ABOVE, BYTE_MAX));
      else
        sym = tracker.pick_loaded();
      send_cmd(CMD_PLACE, ln, sym);
    end
    if ($urandom_range(0, 4) == 0)
      send_cmd(CMD_END, 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         pick, c, s;
    bit         held;
    held = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_invert(1'b0);

    // Font setup: fixed-width glyphs for the directed checks (first and last
    // symbol included, so font addresses 0 and 2399 are hit), then a few more.
    load_glyph(SYM_NARROW, 8'd10);
    load_glyph(SYM_SPAN, 8'd120);
    load_glyph(SYM_HALF, 8'd128);
    load_glyph(SYM_LAST, 8'd255);
    repeat (8) begin
      s = $urandom_range(SYM_SPAN + 1, SYM_LAST - 1);
      if (s == SYM_HALF) s = SYM_HALF + 1;
      load_glyph(s, pick_width());
    end

    // Directed part
    send_word(CMD_LOAD, LINE_TOP, 8'd0, 12'(FONT_SIZE), BYTE_MAX);  // past the store: ignored
    send_word(CMD_LOAD, LINE_TOP, 8'd0, ADDR_MAX, 8'h00);           // ignored too
    send_cmd(CMD_BEGIN, LINE_TOP, BYTE_MAX);
    send_cmd(CMD_BEGIN, LINE_BOTTOM, 8'd0);
    send_cmd(CMD_BEGIN, LINE_ALT_LO, 8'd0);                     // begin on 0/3: no-op
    send_cmd(CMD_BEGIN, LINE_ALT_HI, 8'd0);
    send_cmd(CMD_PLACE, LINE_TOP, SYM_NARROW);                  // ok, top cursor 10
    send_cmd(CMD_PLACE, LINE_TOP, SYM_BELOW);                   // bad symbols
    send_cmd(CMD_PLACE, LINE_TOP, SYM_ABOVE);
    send_cmd(CMD_PLACE, LINE_BOTTOM, 8'd0);
    send_cmd(CMD_PLACE, LINE_BOTTOM, BYTE_MAX);
    send_cmd(CMD_PLACE, LINE_BOTTOM, SYM_LAST);                 // cursor 255: line full
    send_cmd(CMD_PLACE, LINE_BOTTOM, SYM_NARROW);               // full line: ignored
    send_cmd(CMD_PLACE, LINE_ALT_LO, SYM_HALF);                 // top becomes full
    send_cmd(CMD_PLACE, LINE_ALT_HI, SYM_NARROW);               // full line: ignored
    send_cmd(CMD_END, LINE_ALT_HI, BYTE_MAX);
    send_cmd(CMD_PLACE, LINE_TOP, SYM_SPAN);                    // top cursor 120
    send_cmd(CMD_PLACE, LINE_TOP, SYM_NARROW);                  // clipped at the edge, full
    send_cmd(CMD_PLACE, LINE_BOTTOM, SYM_SPAN);
    send_cmd(CMD_PLACE, LINE_BOTTOM, SYM_LAST);                 // cursor saturates at 255
    for (c = CMD_REFRESH + 1; c <= CMD_TOP_CODE; c++)
      send_cmd(3'(c), 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)));
    wait_drained();
    write_invert(1'b1);
    repeat (6)
      send_cmd(CMD_REFRESH, 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)));

    // Random part: mostly text lines and refresh runs, some font reloads,
    // noise words and invert changes between phases.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= CALM_AFTER) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end else begin
        source_gaps = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
      end
      if (!held && words_sent >= HOLD_AFTER) begin
        // sink holds off while a page worth of ticks is offered
        held = 1'b1;
        hold_display = 1'b1;
        repeat (PAGE_SPAN)
          send_cmd(CMD_REFRESH, 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)));
      end
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        text_phase();
      end else if (pick < 14) begin
        repeat ($urandom_range(20, 200))
          send_cmd(CMD_REFRESH, 2'($urandom_range(0, 3)), 8'($urandom_range(0, BYTE_MAX)));
      end else if (pick < 16) begin
        load_glyph($urandom_range(FIRST_SYMBOL, SYM_LAST), pick_width());
      end else if (pick < 18) begin
        repeat ($urandom_range(2, 8)) begin
          c = $urandom_range(0, CMD_TOP_CODE);
          s = $urandom_range(0, BYTE_MAX);
          // never place a glyph whose font bytes were not all written
          if (c == CMD_PLACE && s >= FIRST_SYMBOL && s <= SYM_LAST && !tracker.glyph_ready(s))
            s = tracker.pick_loaded();
          send_word(3'(c), 2'($urandom_range(0, 3)), 8'(s),
                    12'($urandom_range(0, ADDR_MAX)), 8'($urandom_range(0, BYTE_MAX)));
        end
      end else begin
        wait_drained();
        write_invert(1'($urandom_range(0, 1)));
      end
    end

    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("checked %0d display words: %0d glyphs placed, %0d refused on a full line, %0d bad",
             tracker.checked, tracker.placed, tracker.refused_full, tracker.refused_bad);
    $display("%0d complete refresh frames, %0d invert writes", tracker.frames, invert_writes);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("text_glyph_framebuffer_refresh_unit_tb: done, clean");
    else
      $display("text_glyph_framebuffer_refresh_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/tgfb_pkg.sv
src/tgfb_ram.sv
src/tgfb_ctrl.sv
src/text_glyph_framebuffer_refresh_unit.sv
tb/sv/text_glyph_framebuffer_refresh_unit_tb.sv
